/* rtl/core/npf_pkg.sv */
// Shared types, register codes and fixed-point helpers for the pair force pipeline.
package npf_pkg;

    // Magnitude width of every clamped intermediate (Q.16, saturates at 2^47-1)
    localparam int MAG_W = 47;
    localparam logic [MAG_W-1:0] MAXV = '1;

    typedef logic [MAG_W-1:0] t_mag;

    // Configuration register codes
    typedef enum logic [1:0] {
        CFG_CUTOFF_SQ        = 2'd0,
        CFG_SIGMA_SQ         = 2'd1,
        CFG_LJ_STRENGTH      = 2'd2,
        CFG_COULOMB_STRENGTH = 2'd3
    } t_cfg_idx;

    // Per-pair geometry that travels with the item
    typedef struct packed {
        logic [2:0][31:0] ad;        // |displacement| per axis
        logic [2:0]       dneg;      // displacement sign per axis
        logic             qneg;      // charge product negative
        logic             zero;      // coincident atoms
        logic             in_range;  // r2 below cutoff
        t_mag             r2q;       // squared distance, Q.16
    } t_geom;

    // Partial products of a 47x47 multiply split at bit 24
    typedef struct packed {
        logic [45:0] hh;
        logic [46:0] hl;
        logic [46:0] lh;
        logic [47:0] ll;
    } t_pp;

    // One stage of the Lennard-Jones power chain
    typedef struct packed {
        t_mag        a;      // sigma^2/r2, later a^3
        t_mag        v;      // running product
        t_mag        c1;     // Coulomb numerator over r2
        logic [31:0] root;   // sqrt(r2), Q.16
        t_geom       geom;
        logic        sat;
        logic        tneg;   // sign of a^6 - a^3/2
        t_pp         pp;
    } t_chain;

    // First half of a Q.16 multiply: four narrow partial products
    function automatic t_pp qmul_split(input t_mag x, input t_mag y);
        t_pp p;
        p.hh = 46'(x[46:24]) * 46'(y[46:24]);
        p.hl = 47'(x[46:24]) * 47'(y[23:0]);
        p.lh = 47'(x[23:0]) * 47'(y[46:24]);
        p.ll = 48'(x[23:0]) * 48'(y[23:0]);
        return p;
    endfunction

    // Second half: sum, drop 16 fraction bits, clamp. Returns {sat, value}.
    function automatic logic [MAG_W:0] qmul_join(input t_pp p);
        logic [93:0] prod;
        logic [77:0] sh;
        logic        sat;
        prod = {p.hh, 48'b0} + {23'b0, p.hl, 24'b0} + {23'b0, p.lh, 24'b0} + {46'b0, p.ll};
        sh   = prod[93:16];
        sat  = |sh[77:47];
        return {sat, sat ? MAXV : sh[46:0]};
    endfunction

    // Clamp a 63-bit quotient. Returns {sat, value}.
    function automatic logic [MAG_W:0] clamp_quot(input logic [62:0] q);
        logic sat;
        sat = |q[62:47];
        return {sat, sat ? MAXV : q[46:0]};
    endfunction

endpackage

/* rtl/core/npf_recur.sv */
// Pipelined digit recurrence: restoring divider or integer square root, one digit per stage.
module npf_recur #(
    parameter int STEPS  = 63,   // result bits, one per stage
    parameter int SQRT   = 0,    // 1: square root of i_num, 0: i_num / i_den
    parameter int DEN_W  = 47,
    parameter int CMP_W  = 48,   // width of partial remainder compare
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [STEPS*(SQRT+1)-1:0] i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [STEPS-1:0]  o_res,
    output logic [SIDE_W-1:0] o_side
);

    localparam int SHIFT = SQRT + 1;
    localparam int NUM_W = STEPS * SHIFT;

    logic [CMP_W-1:0]  r_rem  [STEPS];
    logic [STEPS-1:0]  r_res  [STEPS];
    logic [NUM_W-1:0]  r_num  [STEPS];
    logic [DEN_W-1:0]  r_den  [STEPS];
    logic [SIDE_W-1:0] r_side [STEPS];
    logic              r_vld  [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [CMP_W-1:0]  w_rem_in;
        logic [STEPS-1:0]  w_res_in;
        logic [NUM_W-1:0]  w_num_in;
        logic [DEN_W-1:0]  w_den_in;
        logic [SIDE_W-1:0] w_side_in;
        logic              w_vld_in;
        logic [CMP_W-1:0]  w_part;
        logic [CMP_W-1:0]  w_trial;
        logic              w_ge;

        // stage inputs
        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_res_in  = '0;
            assign w_num_in  = i_num;
            assign w_den_in  = i_den;
            assign w_side_in = i_side;
            assign w_vld_in  = i_valid;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_res_in  = r_res[k-1];
            assign w_num_in  = r_num[k-1];
            assign w_den_in  = r_den[k-1];
            assign w_side_in = r_side[k-1];
            assign w_vld_in  = r_vld[k-1];
        end

        // bring down the next digit of the operand
        assign w_part = {w_rem_in[CMP_W-SHIFT-1:0], w_num_in[NUM_W-1-SHIFT*k -: SHIFT]};

        // trial subtrahend: 4*root+1 for square root, divisor otherwise
        if (SQRT != 0) begin : g_sqrt
            assign w_trial = {{(CMP_W-STEPS-2){1'b0}}, w_res_in, 2'b01};
        end else begin : g_div
            assign w_trial = {{(CMP_W-DEN_W){1'b0}}, w_den_in};
        end

        assign w_ge = (w_part >= w_trial);

        // payload advances without reset
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? (w_part - w_trial) : w_part;
                r_res[k]  <= {w_res_in[STEPS-2:0], w_ge};
                r_num[k]  <= w_num_in;
                r_den[k]  <= w_den_in;
                r_side[k] <= w_side_in;
            end
        end

        // valid bit per stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld_in;
            end
        end
    end

    assign o_valid = r_vld[STEPS-1];
    assign o_res   = r_res[STEPS-1];
    assign o_side  = r_side[STEPS-1];

endmodule

/* rtl/core/nonbonded_pair_force.sv */
// Lennard-Jones plus Coulomb pair force pipeline with cutoff, top level.
//
// Input stream: one atom pair per transfer on the s_axis group (positions and charges
// packed in tdata). Output stream: one force result per pair on the m_axis group,
// force components in tdata and the in_range / coincident / saturated flags in tuser.
// The configuration channel writes cutoff_sq, sigma_sq, lj_strength and
// coulomb_strength by index; it is always ready, and the user must write it only
// while the pipeline holds no item; the block itself does not enforce this.
// Throughput: one pair per cycle while the receiver does not stall. The pair passes
// through the front end, the square root (32 stages), two chained 63-stage restoring
// dividers, the 10-stage power chain and the back end; front and back end have 7 stages.
// Reset clears all valid bits and loads the register defaults; the pipeline then
// accepts a pair every cycle. When the receiver stalls, the whole pipeline holds
// and s_axis tready drops; nothing is lost or repeated.
module nonbonded_pair_force #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // pair input
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [31:0] first_x, [63:32] first_y, [95:64] first_z, [100:96] first_charge,
    // [132:101] second_x, [164:133] second_y, [196:165] second_z,
    // [201:197] second_charge, [207:202] zero
    input  logic [207:0] i_s_axis_tdata,
    // force output
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [47:0] force_x, [95:48] force_y, [143:96] force_z
    output logic [143:0] o_m_axis_tdata,
    // [0] in_range, [1] coincident, [2] saturated
    output logic [2:0]   o_m_axis_tuser,
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    import npf_pkg::*;

    localparam int SH     = 2 * COORD_FRAC_BITS - 16;
    localparam int GEOM_W = $bits(t_geom);
    localparam int CQ_W   = 41;
    localparam int NCH    = 10;

    logic w_adv;

    // configuration registers
    logic [31:0] r_cutoff_sq, r_sigma_sq, r_lj_strength, r_coulomb_strength;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff_sq        <= 32'd409600;
            r_sigma_sq         <= 32'd65536;
            r_lj_strength      <= 32'd3145728;
            r_coulomb_strength <= 32'd65536;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CUTOFF_SQ:        r_cutoff_sq        <= i_cfg_data;
                CFG_SIGMA_SQ:         r_sigma_sq         <= i_cfg_data;
                CFG_LJ_STRENGTH:      r_lj_strength      <= i_cfg_data;
                CFG_COULOMB_STRENGTH: r_coulomb_strength <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // whole pipeline moves when the output register is free
    logic r_out_v;
    assign w_adv           = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    // ---------------- stage 1: displacement and charge product ----------------
    logic              r1_v, r2_v, r3_v;
    logic [2:0][31:0]  r1_ad, r2_ad, r3_ad;
    logic [2:0]        r1_dneg, r2_dneg, r3_dneg;
    logic [8:0]        r1_aq, r2_aq;
    logic              r1_qneg, r2_qneg, r3_qneg;
    logic [2:0][32:0]  w_d;
    logic signed [9:0] w_q;

    always_comb begin
        w_d[0] = {i_s_axis_tdata[31],  i_s_axis_tdata[31:0]}
               - {i_s_axis_tdata[132], i_s_axis_tdata[132:101]};
        w_d[1] = {i_s_axis_tdata[63],  i_s_axis_tdata[63:32]}
               - {i_s_axis_tdata[164], i_s_axis_tdata[164:133]};
        w_d[2] = {i_s_axis_tdata[95],  i_s_axis_tdata[95:64]}
               - {i_s_axis_tdata[196], i_s_axis_tdata[196:165]};
        w_q    = $signed(i_s_axis_tdata[100:96]) * $signed(i_s_axis_tdata[201:197]);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r1_ad[i]   <= w_d[i][32] ? 32'(-w_d[i]) : w_d[i][31:0];
                r1_dneg[i] <= w_d[i][32];
            end
            r1_aq   <= w_q[9] ? 9'(-w_q) : w_q[8:0];
            r1_qneg <= w_q[9];
        end
    end

    // ---------------- stage 2: squares ----------------
    logic [2:0][63:0] r2_sq;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r2_sq[i] <= 64'(r1_ad[i]) * 64'(r1_ad[i]);
            end
            r2_ad   <= r1_ad;
            r2_dneg <= r1_dneg;
            r2_aq   <= r1_aq;
            r2_qneg <= r1_qneg;
        end
    end

    // ---------------- stage 3: squared distance in Q.16, Coulomb numerator ----------------
    logic [65:0]     w_sum;
    logic [63:0]     w_shr;
    t_mag            w_r2q;
    t_mag            r3_r2q;
    logic            r3_zero;
    logic [CQ_W-1:0] r3_cq;

    always_comb begin
        w_sum = 66'(r2_sq[0]) + 66'(r2_sq[1]) + 66'(r2_sq[2]);
        w_shr = w_sum[63:0] >> SH;
        if (w_sum[65:64] != 2'b0 || w_shr[63:47] != '0) begin
            w_r2q = MAXV;
        end else begin
            w_r2q = w_shr[46:0];
        end
        // nonzero distance below one LSB counts as one LSB
        if (w_sum != '0 && w_r2q == '0) begin
            w_r2q = 47'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_r2q  <= w_r2q;
            r3_zero <= (w_sum == '0);
            r3_cq   <= CQ_W'(r_coulomb_strength) * CQ_W'(r2_aq);
            r3_ad   <= r2_ad;
            r3_dneg <= r2_dneg;
            r3_qneg <= r2_qneg;
        end
    end

    // front-end valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_s_axis_tvalid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // ---------------- square root of r2 ----------------
    t_geom                   w_geom3;
    logic                    w_sq_v;
    logic [31:0]             w_root;
    logic [GEOM_W+CQ_W-1:0]  w_sq_side;
    t_geom                   w_sq_geom;
    logic [CQ_W-1:0]         w_sq_cq;

    always_comb begin
        w_geom3.ad       = r3_ad;
        w_geom3.dneg     = r3_dneg;
        w_geom3.qneg     = r3_qneg;
        w_geom3.zero     = r3_zero;
        w_geom3.in_range = (r3_r2q < {15'b0, r_cutoff_sq});
        w_geom3.r2q      = r3_r2q;
    end

    npf_recur #(
        .STEPS(32), .SQRT(1), .DEN_W(1), .CMP_W(35), .SIDE_W(GEOM_W + CQ_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r3_v),
        .i_num   ({1'b0, r3_r2q, 16'b0}),
        .i_den   (1'b0),
        .i_side  ({w_geom3, r3_cq}),
        .o_valid (w_sq_v),
        .o_res   (w_root),
        .o_side  (w_sq_side)
    );

    assign w_sq_geom = t_geom'(w_sq_side[GEOM_W+CQ_W-1:CQ_W]);
    assign w_sq_cq   = w_sq_side[CQ_W-1:0];

    // ---------------- sigma^2/r2 and Coulomb numerator / r2 ----------------
    logic              w_da_v, w_dc_v;
    logic [62:0]       w_da_q, w_dc_q;
    logic [GEOM_W-1:0] w_da_side;
    logic [31:0]       w_dc_side;

    npf_recur #(
        .STEPS(63), .SQRT(0), .DEN_W(MAG_W), .CMP_W(48), .SIDE_W(GEOM_W)
    ) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_sq_v),
        .i_num   ({15'b0, r_sigma_sq, 16'b0}),
        .i_den   (w_sq_geom.r2q),
        .i_side  (w_sq_geom),
        .o_valid (w_da_v),
        .o_res   (w_da_q),
        .o_side  (w_da_side)
    );

    npf_recur #(
        .STEPS(63), .SQRT(0), .DEN_W(MAG_W), .CMP_W(48), .SIDE_W(32)
    ) u_div_c1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_sq_v),
        .i_num   ({6'b0, w_sq_cq, 16'b0}),
        .i_den   (w_sq_geom.r2q),
        .i_side  (w_root),
        .o_valid (w_dc_v),
        .o_res   (w_dc_q),
        .o_side  (w_dc_side)
    );

    // ---------------- power chain: a^2, a^3, a^6, t, lj*|t| ----------------
    t_chain          r_ch   [NCH];
    logic            r_ch_v [NCH];
    t_chain          n_ch   [NCH];
    logic [MAG_W:0]  w_ca, w_cc, w_j2, w_j4, w_j6, w_j9;
    logic [47:0]     w_t, w_tabs;

    always_comb begin
        w_ca = clamp_quot(w_da_q);
        w_cc = clamp_quot(w_dc_q);
        // entry from the dividers
        n_ch[0]      = '0;
        n_ch[0].a    = w_ca[MAG_W-1:0];
        n_ch[0].c1   = w_cc[MAG_W-1:0];
        n_ch[0].root = w_dc_side;
        n_ch[0].geom = t_geom'(w_da_side);
        n_ch[0].sat  = w_ca[MAG_W] | w_cc[MAG_W];
        for (int k = 1; k < NCH; k++) begin
            n_ch[k] = r_ch[k-1];
        end
        // a*a
        n_ch[1].pp  = qmul_split(r_ch[0].a, r_ch[0].a);
        w_j2        = qmul_join(r_ch[1].pp);
        n_ch[2].v   = w_j2[MAG_W-1:0];
        n_ch[2].sat = r_ch[1].sat | w_j2[MAG_W];
        // (a*a)*a
        n_ch[3].pp  = qmul_split(r_ch[2].v, r_ch[2].a);
        w_j4        = qmul_join(r_ch[3].pp);
        n_ch[4].v   = w_j4[MAG_W-1:0];
        n_ch[4].sat = r_ch[3].sat | w_j4[MAG_W];
        // a3*a3, keep a3 in place of a
        n_ch[5].a   = r_ch[4].v;
        n_ch[5].pp  = qmul_split(r_ch[4].v, r_ch[4].v);
        w_j6        = qmul_join(r_ch[5].pp);
        n_ch[6].v   = w_j6[MAG_W-1:0];
        n_ch[6].sat = r_ch[5].sat | w_j6[MAG_W];
        // t = a6 - a3/2
        w_t          = {1'b0, r_ch[6].v} - {2'b0, r_ch[6].a[46:1]};
        w_tabs       = w_t[47] ? -w_t : w_t;
        n_ch[7].v    = w_tabs[46:0];
        n_ch[7].tneg = w_t[47];
        // lj_strength * |t|
        n_ch[8].pp  = qmul_split({15'b0, r_lj_strength}, r_ch[7].v);
        w_j9        = qmul_join(r_ch[8].pp);
        n_ch[9].v   = w_j9[MAG_W-1:0];
        n_ch[9].sat = r_ch[8].sat | w_j9[MAG_W];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < NCH; k++) begin
                r_ch[k] <= n_ch[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NCH; k++) begin
                r_ch_v[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_ch_v[0] <= w_da_v;
            for (int k = 1; k < NCH; k++) begin
                r_ch_v[k] <= r_ch_v[k-1];
            end
        end
    end

    // ---------------- LJ part / r2 and Coulomb part / r ----------------
    logic              w_dl_v, w_dc2_v;
    logic [62:0]       w_dl_q, w_dc2_q;
    logic [GEOM_W:0]   w_dl_side;
    logic              w_dc2_side;
    t_geom             w_dl_geom;

    npf_recur #(
        .STEPS(63), .SQRT(0), .DEN_W(MAG_W), .CMP_W(48), .SIDE_W(GEOM_W + 1)
    ) u_div_lj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_ch_v[NCH-1]),
        .i_num   ({r_ch[NCH-1].v, 16'b0}),
        .i_den   (r_ch[NCH-1].geom.r2q),
        .i_side  ({r_ch[NCH-1].geom, r_ch[NCH-1].sat}),
        .o_valid (w_dl_v),
        .o_res   (w_dl_q),
        .o_side  (w_dl_side)
    );

    npf_recur #(
        .STEPS(63), .SQRT(0), .DEN_W(MAG_W), .CMP_W(48), .SIDE_W(1)
    ) u_div_c2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_ch_v[NCH-1]),
        .i_num   ({r_ch[NCH-1].c1, 16'b0}),
        .i_den   ({15'b0, r_ch[NCH-1].root}),
        .i_side  (r_ch[NCH-1].tneg),
        .o_valid (w_dc2_v),
        .o_res   (w_dc2_q),
        .o_side  (w_dc2_side)
    );

    assign w_dl_geom = t_geom'(w_dl_side[GEOM_W:1]);

    // ---------------- stage F: signed LJ and Coulomb parts ----------------
    logic              r_f_v, r_g_v, r_h_v;
    logic [47:0]       r_f_slj, r_f_sc;
    t_geom             r_f_geom, r_g_geom, r_h_geom;
    logic              r_f_sat, r_g_sat, r_h_sat;
    logic [MAG_W:0]    w_cl, w_cv;

    always_comb begin
        w_cl = clamp_quot(w_dl_q);
        w_cv = clamp_quot(w_dc2_q);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f_slj  <= w_dc2_side ? -{1'b0, w_cl[MAG_W-1:0]} : {1'b0, w_cl[MAG_W-1:0]};
            r_f_sc   <= w_dl_geom.qneg ? -{1'b0, w_cv[MAG_W-1:0]}
                                       : {1'b0, w_cv[MAG_W-1:0]};
            r_f_geom <= w_dl_geom;
            r_f_sat  <= w_dl_side[0] | w_cl[MAG_W] | w_cv[MAG_W];
        end
    end

    // ---------------- stage G: total scalar, magnitude and sign ----------------
    logic [48:0] w_st;
    logic [47:0] r_g_mag;
    logic        r_g_stneg;

    assign w_st = {r_f_slj[47], r_f_slj} + {r_f_sc[47], r_f_sc};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_g_mag   <= w_st[48] ? 48'(-w_st) : w_st[47:0];
            r_g_stneg <= w_st[48];
            r_g_geom  <= r_f_geom;
            r_g_sat   <= r_f_sat;
        end
    end

    // ---------------- stage H1: |S| * |d| partial products ----------------
    logic [2:0][55:0] r_h_plo, r_h_phi;
    logic             r_h_stneg;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_h_plo[i] <= 56'(r_g_mag[23:0])  * 56'(r_g_geom.ad[i]);
                r_h_phi[i] <= 56'(r_g_mag[47:24]) * 56'(r_g_geom.ad[i]);
            end
            r_h_stneg <= r_g_stneg;
            r_h_geom  <= r_g_geom;
            r_h_sat   <= r_g_sat;
        end
    end

    // ---------------- stage H2: scale, clamp, sign, output register ----------------
    logic [2:0][79:0] w_prod;
    logic [2:0][79:0] w_scl;
    logic [2:0][47:0] w_force;
    logic [2:0]       w_fsat;
    logic             w_active;
    logic [2:0][47:0] r_out_force;
    logic             r_out_in_range, r_out_zero, r_out_sat;

    always_comb begin
        w_active = r_h_geom.in_range && !r_h_geom.zero;
        for (int i = 0; i < 3; i++) begin
            w_prod[i]  = {r_h_phi[i], 24'b0} + {24'b0, r_h_plo[i]};
            w_scl[i]   = w_prod[i] >> COORD_FRAC_BITS;
            w_fsat[i]  = |w_scl[i][79:47];
            w_force[i] = {1'b0, w_fsat[i] ? MAXV : w_scl[i][46:0]};
            if (r_h_stneg != r_h_geom.dneg[i]) begin
                w_force[i] = -w_force[i];
            end
            if (!w_active) begin
                w_force[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_force    <= w_force;
            r_out_in_range <= r_h_geom.in_range;
            r_out_zero     <= r_h_geom.zero;
            r_out_sat      <= w_active && (r_h_sat || (|w_fsat));
        end
    end

    // back-end valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v   <= 1'b0;
            r_g_v   <= 1'b0;
            r_h_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_f_v   <= w_dl_v;
            r_g_v   <= r_f_v;
            r_h_v   <= r_g_v;
            r_out_v <= r_h_v;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {r_out_force[2], r_out_force[1], r_out_force[0]};
    assign o_m_axis_tuser  = {r_out_sat, r_out_zero, r_out_in_range};

    // ---------------- assertions ----------------
    a_units_paired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_da_v == w_dc_v) && (w_dl_v == w_dc2_v))
        else $error("parallel dividers out of step");

    a_coincident_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out_zero |-> (o_m_axis_tdata == '0) && !r_out_sat)
        else $error("coincident pair with nonzero force");

    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !r_out_in_range |-> (o_m_axis_tdata == '0) && !r_out_sat)
        else $error("pair beyond cutoff with nonzero force");

    a_entry_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r1_v)
        else $error("accepted pair not captured");

endmodule

/* sim/tb_nonbonded_pair_force.sv */
// Self-checking testbench for the Lennard-Jones plus Coulomb pair force pipeline.
module tb_nonbonded_pair_force;
    timeunit 1ns;
    timeprecision 1ps;
    import npf_pkg::*;

    localparam int FRAC = 16;
    localparam logic [63:0] MAXF = (64'd1 << 47) - 1;
    localparam int LATENCY = 175;

    typedef struct packed {
        logic [47:0] fx;
        logic [47:0] fy;
        logic [47:0] fz;
        logic        in_range;
        logic        coincident;
        logic        saturated;
    } t_force;

    // Predicted force results, checked in order
    class force_board;
        logic [31:0] cutoff_sq, sigma_sq, lj_k, coul_k;
        t_force      pending[$];
        int          errors;

        function new();
            cutoff_sq = 32'd409600;
            sigma_sq  = 32'd65536;
            lj_k      = 32'd3145728;
            coul_k    = 32'd65536;
            errors    = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] v);
            case (idx)
                CFG_CUTOFF_SQ:        cutoff_sq = v;
                CFG_SIGMA_SQ:         sigma_sq  = v;
                CFG_LJ_STRENGTH:      lj_k      = v;
                CFG_COULOMB_STRENGTH: coul_k    = v;
                default: ;
            endcase
        endfunction

        function logic [63:0] clamp(logic [127:0] v, inout bit sat);
            if (v > MAXF) begin
                sat = 1;
                return MAXF;
            end
            return v[63:0];
        endfunction

        function logic [63:0] qmul(logic [63:0] a, logic [63:0] b, inout bit sat);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return clamp(p >> 16, sat);
        endfunction

        function logic [63:0] qdiv(logic [63:0] n, logic [63:0] den, inout bit sat);
            logic [127:0] q;
            q = ({64'd0, n} << 16) / {64'd0, den};
            return clamp(q, sat);
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] x);
            logic [63:0] root, bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > x) bitv >>= 2;
            while (bitv != 0) begin
                if (x >= root + bitv) begin
                    x -= root + bitv;
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            return root;
        endfunction

        // Work out the force for one accepted pair
        function void note_pair(logic [207:0] td);
            logic signed [63:0] d[3];
            logic [63:0]        ad[3];
            logic [127:0]       sum;
            logic [63:0]        r2, a, a3, a6, at, lj, cq, cv, r, mag, f;
            logic signed [63:0] q, t, slj, sc, st, fr[3];
            logic [63:0]        aq;
            bit                 sat, zero, inr;
            t_force             res;
            sum = 0;
            sat = 0;
            for (int i = 0; i < 3; i++) begin
                d[i] = 64'(signed'(td[32*i +: 32])) - 64'(signed'(td[101+32*i +: 32]));
                ad[i] = d[i] < 0 ? -d[i] : d[i];
                sum += {64'd0, ad[i]} * {64'd0, ad[i]};
                fr[i] = 0;
            end
            zero = (sum == 0);
            r2 = (sum >> (2*FRAC-16)) > MAXF ? MAXF : 64'(sum >> (2*FRAC-16));
            if (!zero && r2 == 0) r2 = 1;
            inr = r2 < {32'd0, cutoff_sq};
            if (inr && !zero) begin
                q = 64'(signed'(td[100:96])) * 64'(signed'(td[201:197]));
                aq = q < 0 ? -q : q;
                a  = qdiv(sigma_sq, r2, sat);
                a3 = qmul(qmul(a, a, sat), a, sat);
                a6 = qmul(a3, a3, sat);
                t  = signed'(a6) - signed'(a3 >> 1);
                at = t < 0 ? -t : t;
                lj = qdiv(qmul(lj_k, at, sat), r2, sat);
                slj = t < 0 ? -signed'(lj) : signed'(lj);
                cq = clamp({64'd0, coul_k} * {64'd0, aq}, sat);
                r  = int_sqrt(r2 << 16);
                cv = qdiv(qdiv(cq, r2, sat), r, sat);
                sc = q < 0 ? -signed'(cv) : signed'(cv);
                st = slj + sc;
                mag = st < 0 ? -st : st;
                for (int i = 0; i < 3; i++) begin
                    if (ad[i] != 0 && mag != 0) begin
                        f = clamp(({64'd0, mag} * {64'd0, ad[i]}) >> FRAC, sat);
                        fr[i] = ((st < 0) != (d[i] < 0)) ? -signed'(f) : signed'(f);
                    end
                end
            end
            res.fx = fr[0][47:0];
            res.fy = fr[1][47:0];
            res.fz = fr[2][47:0];
            res.in_range = inr;
            res.coincident = zero;
            res.saturated = sat;
            pending = {pending, res};
        endfunction

        function void check_force(logic [143:0] td, logic [2:0] tu);
            t_force got, exp_f;
            got = {td[47:0], td[95:48], td[143:96], tu[0], tu[1], tu[2]};
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
                return;
            end
            exp_f = pending.pop_front();
            if (got !== exp_f) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: exp fx=%h fy=%h fz=%h ir=%b co=%b sat=%b",
                        exp_f.fx, exp_f.fy, exp_f.fz, exp_f.in_range, exp_f.coincident,
                        exp_f.saturated);
                    $display("          got fx=%h fy=%h fz=%h ir=%b co=%b sat=%b",
                        got.fx, got.fy, got.fz, got.in_range, got.coincident,
                        got.saturated);
                end
            end
        endfunction
    endclass

    logic         i_clk, i_rst_n;
    logic         i_s_axis_tvalid, o_s_axis_tready;
    logic [207:0] i_s_axis_tdata;
    logic         o_m_axis_tvalid, i_m_axis_tready;
    logic [143:0] o_m_axis_tdata;
    logic [2:0]   o_m_axis_tuser;
    logic         i_cfg_valid, o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    force_board board;
    int send_idle, recv_idle;

    nonbonded_pair_force u_dut (.*);

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // Output side: sample at the rising edge, random stall at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_force(o_m_axis_tdata, o_m_axis_tuser);
    end
    always @(negedge i_clk) begin
        i_m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_idle);
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Called at a falling edge; valid stays up so transfers can follow back to back
    task automatic send_pair(logic [207:0] td);
        while ($urandom_range(99) < send_idle) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= td;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_pair(td);
        @(negedge i_clk);
    endtask

    // Pack one pair: positions and charges
    function automatic logic [207:0] pair(logic [31:0] x1, y1, z1, logic [4:0] q1,
                                          logic [31:0] x2, y2, z2, logic [4:0] q2);
        return {6'd0, q2, z2, y2, x2, q1, z1, y1, x1};
    endfunction

    function automatic logic [31:0] near_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'(signed'($urandom_range(0, 400000)) - 200000);
            2: return 32'(signed'($urandom_range(0, 20)) - 10);
            default: return 32'(signed'($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    function automatic logic [207:0] rand_pair();
        logic [31:0] x, y, z;
        x = $urandom();
        y = $urandom();
        z = $urandom();
        if ($urandom_range(9) == 0)
            return pair(x, y, z, 5'($urandom()), $urandom(), $urandom(), $urandom(),
                        5'($urandom()));
        return pair(x, y, z, 5'($urandom_range(0, 16) - 8),
                    x + near_coord(), y + near_coord(), z + near_coord(),
                    5'($urandom_range(0, 16) - 8));
    endfunction

    // Stop sending and wait for the pipeline to drain before touching registers
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic random_pairs(int n);
        for (int i = 0; i < n; i++) send_pair(rand_pair());
    endtask

    initial begin
        board = new();
        send_idle = 37;
        recv_idle = 78;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_CUTOFF_SQ;
        i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, coincident, sub-resolution, cutoff edge, odd charges
        send_pair(pair(0, 0, 0, 5'd1, 0, 0, 0, 5'd1));
        send_pair(pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 5'd8,
                       32'h80000000, 32'h80000000, 32'h80000000, 5'h18));
        send_pair(pair(1, 0, 0, 5'd8, 0, 0, 0, 5'd8));
        send_pair(pair(300, 0, 0, 5'h18, 0, 0, 0, 5'd8));
        send_pair(pair(32'h10000, 0, 0, 5'd1, 0, 0, 0, 5'h1f));
        send_pair(pair(0, 32'h10000, 0, 5'd0, 0, 0, 0, 5'd3));
        send_pair(pair(0, 0, 32'h28000, 5'd2, 0, 0, 0, 5'd2));
        send_pair(pair(0, 0, 32'h27fff, 5'd2, 0, 0, 0, 5'd2));
        send_pair(pair(32'h8000, 32'h8000, 32'h8000, 5'h0f, 0, 0, 0, 5'h10));
        send_pair(pair(32'h18000, 32'hffff0000, 32'h4000, 5'd4, 0, 0, 0, 5'h1c));
        send_pair(pair(32'hffffffff, 0, 0, 5'd8, 0, 0, 0, 5'd8));
        send_pair(pair(32'h1c000, 32'h1000, 0, 5'd0, 0, 0, 0, 5'd0));
        random_pairs(480);
        drain();

        // Extreme settings
        send_idle = 78;
        recv_idle = 37;
        write_reg(CFG_CUTOFF_SQ, 32'hffffffff);
        write_reg(CFG_SIGMA_SQ, 32'hffffffff);
        write_reg(CFG_LJ_STRENGTH, 32'hffffffff);
        write_reg(CFG_COULOMB_STRENGTH, 32'hffffffff);
        send_pair(pair(32'h100, 0, 0, 5'd8, 0, 0, 0, 5'd8));
        random_pairs(250);
        drain();
        write_reg(CFG_CUTOFF_SQ, 0);
        write_reg(CFG_SIGMA_SQ, 0);
        write_reg(CFG_LJ_STRENGTH, 0);
        write_reg(CFG_COULOMB_STRENGTH, 0);
        send_pair(pair(0, 0, 0, 5'd1, 0, 0, 0, 5'd1));
        random_pairs(100);
        drain();

        // Random settings, then the defaults again; no idling
        send_idle = 0;
        recv_idle = 0;
        write_reg(CFG_CUTOFF_SQ, $urandom());
        write_reg(CFG_SIGMA_SQ, $urandom_range(0, 32'h40000));
        write_reg(CFG_LJ_STRENGTH, $urandom());
        write_reg(CFG_COULOMB_STRENGTH, $urandom_range(0, 32'h100000));
        random_pairs(300);
        drain();
        write_reg(CFG_CUTOFF_SQ, 32'd409600);
        write_reg(CFG_SIGMA_SQ, 32'd65536);
        write_reg(CFG_LJ_STRENGTH, 32'd3145728);
        write_reg(CFG_COULOMB_STRENGTH, 32'd65536);
        random_pairs(350);
        drain();

        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule

/* files.f */
rtl/core/npf_pkg.sv
rtl/core/npf_recur.sv
rtl/core/nonbonded_pair_force.sv
sim/tb_nonbonded_pair_force.sv
